### rtl/core/cfc_pkg.sv
package cfc_pkg;

   localparam int unsigned DepthWidth = 6;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned TermWidth  = 9;
   localparam logic [DepthWidth-1:0] PiLastIndex = 6'd10;

   typedef enum logic {
      SEL_E  = 1'b0,
      SEL_PI = 1'b1
   } sel_type;

   typedef struct packed {
      logic                  command;
      logic [DepthWidth-1:0] depth;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] numerator;
      logic [ValueWidth-1:0] denominator;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic capture;
   } ctl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

   // Partial quotients of pi, entries 0 through 10.
   function automatic logic [TermWidth-1:0] pi_term(input logic [3:0] idx);
      logic [TermWidth-1:0] t;
      case (idx)
         4'd0:    t = 9'd3;
         4'd1:    t = 9'd7;
         4'd2:    t = 9'd15;
         4'd3:    t = 9'd1;
         4'd4:    t = 9'd292;
         4'd5:    t = 9'd1;
         4'd6:    t = 9'd1;
         4'd7:    t = 9'd1;
         4'd8:    t = 9'd2;
         4'd9:    t = 9'd1;
         4'd10:   t = 9'd3;
         default: t = 9'd0;
      endcase
      return t;
   endfunction

endpackage

### rtl/core/cfc_ctrl.sv
module cfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cfc_pkg::dp_status_type status,
   output cfc_pkg::ctl_cmd_type   cmd
);
   import cfc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step    = !status.done;
            cmd.capture = status.done;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/cfc_datapath.sv
module cfc_datapath #(
   parameter int unsigned MAX_DEPTH = 63
) (
   input  logic                   clock,
   input  cfc_pkg::req_type       req_data,
   input  cfc_pkg::ctl_cmd_type   cmd,
   output cfc_pkg::dp_status_type status,
   output cfc_pkg::rsp_type       rsp_data
);
   import cfc_pkg::*;

   logic [ValueWidth-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [ValueWidth-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [DepthWidth:0]   idx_ff, idx_in;
   logic [DepthWidth-1:0] lim_ff, lim_in;
   logic [1:0]            phase_ff, phase_in;
   logic [TermWidth-1:0]  even_ff, even_in;
   sel_type               sel_ff, sel_in;
   rsp_type               rsp_ff, rsp_in;

   logic [DepthWidth-1:0] depth_sat;
   logic [TermWidth-1:0]  term;
   logic [ValueWidth-1:0] pn, qn;

   always_comb begin
      if ({2'b00, req_data.depth} > 8'(MAX_DEPTH)) begin
         depth_sat = DepthWidth'(MAX_DEPTH);
      end else begin
         depth_sat = req_data.depth;
      end
   end

   // The e terms follow the index mod 3: every third step uses the next even number.
   always_comb begin
      if (sel_ff == SEL_PI) begin
         term = pi_term(idx_ff[3:0]);
      end else if (phase_ff == 2'd2) begin
         term = even_ff;
      end else begin
         term = 9'd1;
      end
   end

   assign pn = pb_ff * {{(ValueWidth-TermWidth){1'b0}}, term} + pa_ff;
   assign qn = qb_ff * {{(ValueWidth-TermWidth){1'b0}}, term} + qa_ff;

   always_comb begin
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      idx_in   = idx_ff;
      lim_in   = lim_ff;
      phase_in = phase_ff;
      even_in  = even_ff;
      sel_in   = sel_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         if (req_data.command) begin
            sel_in = SEL_PI;
            pa_in  = 64'd1;
            pb_in  = 64'd3;
            qa_in  = 64'd0;
            qb_in  = 64'd1;
            idx_in = 7'd1;
            lim_in = (depth_sat > PiLastIndex) ? PiLastIndex : depth_sat;
         end else begin
            sel_in = SEL_E;
            pa_in  = 64'd2;
            // Depth zero never steps, so the first convergent sits in pb directly.
            pb_in  = (depth_sat == '0) ? 64'd2 : 64'd3;
            qa_in  = 64'd1;
            qb_in  = 64'd1;
            idx_in = 7'd2;
            lim_in = depth_sat;
         end
         phase_in = 2'd2;
         even_in  = 9'd2;
      end else if (cmd.step) begin
         pa_in  = pb_ff;
         pb_in  = pn;
         qa_in  = qb_ff;
         qb_in  = qn;
         idx_in = idx_ff + 7'd1;
         if (phase_ff == 2'd2) begin
            phase_in = 2'd0;
            even_in  = even_ff + 9'd2;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
      if (cmd.capture) begin
         rsp_in.numerator   = pb_ff;
         rsp_in.denominator = qb_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
      idx_ff   <= idx_in;
      lim_ff   <= lim_in;
      phase_ff <= phase_in;
      even_ff  <= even_in;
      sel_ff   <= sel_in;
      rsp_ff   <= rsp_in;
   end

   // The index carries one extra bit so that it can pass a limit of 63.
   assign status.done = (idx_ff > {1'b0, lim_ff});
   assign rsp_data    = rsp_ff;

endmodule

### rtl/core/continued_fraction_convergent.sv
// Convergents of the simple continued fractions of e and pi.
// A request beat on req_ carries a selector (0 = e, 1 = pi) and a depth n;
// the block answers with one rsp_ beat holding the 64-bit numerator and
// denominator of the n-th convergent, both wrapping modulo 2^64.
// Depths above MAX_DEPTH saturate to it; pi depths above 10 give the
// depth-10 convergent.
// One recurrence step runs per cycle through a single 64 x 9 bit
// multiply-add pair. A request runs s steps, s = max(n - 1, 0) for e and
// min(n, 10) for pi, after which the result is captured into the output
// register and offered as the rsp_ beat.
// Requests are handled one at a time; req_ready is high only while the block
// is idle, so no new request is taken until the result beat is accepted.
// The result is held in an output register; while the receiver stalls,
// rsp_valid and rsp_data stay unchanged and no new request is taken.
// Synchronous reset returns the controller to idle and drops any pending
// result; the datapath needs no reset.
module continued_fraction_convergent #(
   parameter int unsigned MAX_DEPTH = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfc_pkg::rsp_type  rsp_data
);
   import cfc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   cfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfc_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned MaxDepth = 63;
   localparam int unsigned QuietTail = 60;
   localparam int unsigned LongHoldAt = 150;

   // Partial quotients of pi used by the convergent predictor.
   localparam logic [63:0] PiQuotients [11] = '{
      64'd3, 64'd7, 64'd15, 64'd1, 64'd292, 64'd1, 64'd1, 64'd1, 64'd2, 64'd1, 64'd3
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cfc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cfc_pkg::rsp_type rsp_data;

   cfc_pkg::req_type pending_reqs[$];
   cfc_pkg::rsp_type expected_fractions[$];
   int               error_count = 0;
   int               beats_checked = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   bit               long_hold_done = 1'b0;

   continued_fraction_convergent #(
      .MAX_DEPTH(MaxDepth)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Convergent p/q of e or pi at the requested depth, wrapping modulo 2^64.
   function automatic cfc_pkg::rsp_type convergent_of(cfc_pkg::req_type r);
      cfc_pkg::rsp_type frac;
      logic [63:0] p_prev, p_cur, q_prev, q_cur, p_next, q_next, term;
      int unsigned n;
      int unsigned i;
      n = r.depth;
      if (n > MaxDepth) n = MaxDepth;
      if (r.command == cfc_pkg::SEL_E) begin
         p_prev = 64'd2;
         p_cur  = 64'd3;
         q_prev = 64'd1;
         q_cur  = 64'd1;
         if (n == 0) begin
            p_cur = p_prev;
            q_cur = q_prev;
         end
         for (i = 2; i <= n; i++) begin
            term = (i % 3 == 2) ? 64'(2 * ((i + 1) / 3)) : 64'd1;
            p_next = term * p_cur + p_prev;
            q_next = term * q_cur + q_prev;
            p_prev = p_cur;
            p_cur  = p_next;
            q_prev = q_cur;
            q_cur  = q_next;
         end
      end else begin
         // Depths past the end of the quotient table stop at the last entry.
         if (n > 10) n = 10;
         p_prev = 64'd1;
         p_cur  = PiQuotients[0];
         q_prev = 64'd0;
         q_cur  = 64'd1;
         for (i = 1; i <= n; i++) begin
            term = PiQuotients[i];
            p_next = term * p_cur + p_prev;
            q_next = term * q_cur + q_prev;
            p_prev = p_cur;
            p_cur  = p_next;
            q_prev = q_cur;
            q_cur  = q_next;
         end
      end
      frac.numerator   = p_cur;
      frac.denominator = q_cur;
      return frac;
   endfunction

   function automatic void add_request(cfc_pkg::sel_type sel, logic [5:0] depth);
      cfc_pkg::req_type r;
      r.command = sel;
      r.depth   = depth;
      pending_reqs.push_back(r);
   endfunction

   function automatic bit quiet_phase();
      return pending_reqs.size() < QuietTail;
   endfunction

   // Request driver: pops the next pending beat once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: short random stalls, plus one long hold-off so the
   // block backs up and stops taking requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!long_hold_done && beats_checked >= LongHoldAt) begin
         long_hold_done <= 1'b1;
         stall_left     <= 299;
         rsp_ready      <= 1'b0;
      end else if (!quiet_phase() && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Both channels are observed here so that a response and a request on the
   // same edge are ordered correctly.
   always @(posedge clock) begin : scoreboard
      cfc_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               $display("%0t: unexpected response beat: expected none, actual %h/%h",
                        $time, rsp_data.numerator, rsp_data.denominator);
               error_count++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_data.numerator !== want.numerator) begin
                  $display("%0t: numerator mismatch: expected %h, actual %h",
                           $time, want.numerator, rsp_data.numerator);
                  error_count++;
               end
               if (rsp_data.denominator !== want.denominator) begin
                  $display("%0t: denominator mismatch: expected %h, actual %h",
                           $time, want.denominator, rsp_data.denominator);
                  error_count++;
               end
            end
            beats_checked++;
         end
         if (req_valid && req_ready) expected_fractions.push_back(convergent_of(req_data));
      end
   end

   initial begin
      // Directed part: shallow and deepest depths, the pi table edge and
      // depths past it, and the depths where e wraps around 2^64.
      add_request(cfc_pkg::SEL_E, 6'd0);
      add_request(cfc_pkg::SEL_E, 6'd1);
      add_request(cfc_pkg::SEL_E, 6'd2);
      add_request(cfc_pkg::SEL_E, 6'd3);
      add_request(cfc_pkg::SEL_E, 6'd4);
      add_request(cfc_pkg::SEL_E, 6'd5);
      add_request(cfc_pkg::SEL_E, 6'd8);
      add_request(cfc_pkg::SEL_E, 6'd31);
      add_request(cfc_pkg::SEL_E, 6'd32);
      add_request(cfc_pkg::SEL_E, 6'd62);
      add_request(cfc_pkg::SEL_E, 6'd63);
      add_request(cfc_pkg::SEL_PI, 6'd0);
      add_request(cfc_pkg::SEL_PI, 6'd1);
      add_request(cfc_pkg::SEL_PI, 6'd2);
      add_request(cfc_pkg::SEL_PI, 6'd4);
      add_request(cfc_pkg::SEL_PI, 6'd9);
      add_request(cfc_pkg::SEL_PI, 6'd10);
      add_request(cfc_pkg::SEL_PI, 6'd11);
      add_request(cfc_pkg::SEL_PI, 6'd12);
      add_request(cfc_pkg::SEL_PI, 6'd21);
      add_request(cfc_pkg::SEL_PI, 6'd42);
      add_request(cfc_pkg::SEL_PI, 6'd63);
      add_request(cfc_pkg::SEL_E, 6'd0);
      repeat (400) begin
         add_request($urandom_range(0, 1) ? cfc_pkg::SEL_PI : cfc_pkg::SEL_E,
                     6'($urandom_range(0, 63)));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_fractions.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (expected_fractions.size() != 0) begin
         $display("%0t: responses missing: expected %0d more, actual 0",
                  $time, expected_fractions.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("continued_fraction_convergent verification clean");
      end else begin
         $display("continued_fraction_convergent verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("continued_fraction_convergent verification failed");
      $finish;
   end

endmodule
